/* rtl/grv_pkg.sv */
`timescale 1ns / 1ps

package grv_pkg;

  // Field widths fixed by the command format.
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // Element counter width: holds any element position below the size in use.
  localparam int K_W = LEN_W;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAME  = 2'd2;

  // Tag that travels with an operand pair through the rotation datapath.
  // ph 0 computes the new first-vector element, ph 1 the new second one.
  typedef struct packed {
    logic           ph;
    logic [K_W-1:0] k;
  } mac_tag_t;

endpackage

/* rtl/grv_store.sv */
`timescale 1ns / 1ps

module grv_store #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [grv_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [grv_pkg::DATA_W-1:0] rdata_a,
  output logic [grv_pkg::DATA_W-1:0] rdata_b
);
  import grv_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/grv_mac.sv */
`timescale 1ns / 1ps

module grv_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_valid,
  input  grv_pkg::mac_tag_t                 s_tag,
  input  logic signed [grv_pkg::DATA_W-1:0] x,
  input  logic signed [grv_pkg::DATA_W-1:0] y,
  input  logic signed [grv_pkg::DATA_W-1:0] c,
  input  logic signed [grv_pkg::DATA_W-1:0] s,
  output logic                              q_valid,
  output grv_pkg::mac_tag_t                 q_tag,
  output logic [grv_pkg::DATA_W-1:0]        q_val,
  output logic                              busy
);
  import grv_pkg::*;

  localparam int PW = 2 * DATA_W;
  localparam int SW = PW + 1;
  localparam int RW = SW - (DATA_W - 2);

  logic                     v1_r, v2_r, v3_r;
  mac_tag_t                 t1_r, t2_r, t3_r;
  logic signed [PW-1:0]     p1_r, p2_r;
  logic signed [SW-1:0]     sum_r;
  logic [DATA_W-1:0]        q_r;

  logic signed [DATA_W-1:0] m1_op, m2_op;
  logic signed [SW-1:0]     sum_nxt;
  logic signed [SW-1:0]     biased;
  logic [RW-1:0]            rnd;
  logic [DATA_W-1:0]        q_nxt;

  // Phase 0 forms c*x and s*y, phase 1 forms s*x and c*y.
  always_comb begin
    m1_op = s_tag.ph ? s : c;
    m2_op = s_tag.ph ? c : s;
  end

  // Stage 1: the two products.
  always_ff @(posedge clk) begin
    p1_r <= PW'(m1_op) * PW'(x);
    p2_r <= PW'(m2_op) * PW'(y);
    t1_r <= s_tag;
  end

  // Stage 2: exact sum, difference for the first vector.
  always_comb begin
    if (t1_r.ph) begin
      sum_nxt = {p1_r[PW-1], p1_r} + {p2_r[PW-1], p2_r};
    end else begin
      sum_nxt = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    t2_r  <= t1_r;
  end

  // Stage 3: round to nearest with ties upward, then saturate to 32 bits.
  always_comb begin
    biased = sum_r + (SW'(1) <<< (DATA_W - 3));
    rnd    = biased[SW-1:DATA_W-2];
    if ((rnd[RW-1:DATA_W-1] == '0) || (rnd[RW-1:DATA_W-1] == '1)) begin
      q_nxt = rnd[DATA_W-1:0];
    end else if (rnd[RW-1]) begin
      q_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      q_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    t3_r <= t2_r;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= s_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign q_valid = v3_r;
  assign q_tag   = t3_r;
  assign q_val   = q_r;
  assign busy    = v1_r | v2_r | v3_r;

endmodule

/* rtl/givens_rotation_vector_pair_core.sv */
`timescale 1ns / 1ps
// Givens plane rotation engine over a square matrix of stored vectors.
//
// Input channel (in_valid/in_ready): one command beat loads an element,
// reads an element, or rotates two vectors by cosine and sine in Q2.30.
// Output channel (out_valid/out_ready): exactly one beat per command with
// the element read (zero otherwise) and a status code.
// Configuration channel (cfg_valid/cfg_ready): writes vector_length, the
// number of vectors and of elements per vector in use; always ready.
//
// Commands run one at a time. A load or read passes the execute and
// response states before its result beat. In a rotation, the store
// has one write port and each element pair needs two writes, so the
// sequencer reads each pair once and feeds it in phase 0 and 1, one
// new element each, into a three-stage multiply, sum and round pipeline.
// The store content is undefined after reset; vector_length resets to 64.
// A new command is accepted while the previous result waits; if the
// receiver stalls, the next result holds until the output register frees.
module givens_rotation_vector_pair_core #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [grv_pkg::CMD_W-1:0]         in_cmd,
  input  logic [grv_pkg::IDX_W-1:0]         in_first_vector,
  input  logic [grv_pkg::IDX_W-1:0]         in_second_vector,
  input  logic [grv_pkg::IDX_W-1:0]         in_element_index,
  input  logic signed [grv_pkg::DATA_W-1:0] in_load_value,
  input  logic signed [grv_pkg::DATA_W-1:0] in_cos_value,
  input  logic signed [grv_pkg::DATA_W-1:0] in_sin_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [grv_pkg::DATA_W-1:0] out_read_value,
  output logic [grv_pkg::STAT_W-1:0]        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grv_pkg::LEN_W-1:0]         cfg_data
);
  import grv_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = 2 * IW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_ROT   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [LEN_W-1:0]          len_r;
  logic [LEN_W-1:0]          n_use;

  // Latched command.
  logic [CMD_W-1:0]          cmd_r;
  logic [IDX_W-1:0]          vi_r, vj_r, ei_r;
  logic [DATA_W-1:0]         ld_r;
  logic signed [DATA_W-1:0]  c_r, s_r;

  logic [STAT_W-1:0]         status_r, status_nxt;
  logic                      rdres_r, rdres_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic                      ph_r, ph_nxt;
  logic                      s0_valid_r;
  mac_tag_t                  s0_tag_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]         out_read_value_r;
  logic [STAT_W-1:0]         out_status_r;

  logic                      in_fire, resp_fire;
  logic                      vi_bad, vj_bad, ei_bad;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [DATA_W-1:0]         mem_wdata, rdata_a, rdata_b;

  logic                      q_valid, mac_busy;
  mac_tag_t                  q_tag;
  logic [DATA_W-1:0]         q_val;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign resp_fire = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  // Size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  // Size in use, limited to the store's dimension.
  always_comb begin
    if (32'(len_r) > MAX_DIM) begin
      n_use = LEN_W'(MAX_DIM);
    end else begin
      n_use = len_r;
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      vi_r  <= in_first_vector;
      vj_r  <= in_second_vector;
      ei_r  <= in_element_index;
      ld_r  <= in_load_value;
      c_r   <= in_cos_value;
      s_r   <= in_sin_value;
    end
  end

  // Range and status decode of the latched command.
  always_comb begin
    vi_bad     = LEN_W'(vi_r) >= n_use;
    vj_bad     = LEN_W'(vj_r) >= n_use;
    ei_bad     = LEN_W'(ei_r) >= n_use;
    status_nxt = STAT_OK;
    case (cmd_r)
      CMD_LOAD, CMD_READ: begin
        if (vi_bad || ei_bad) begin
          status_nxt = STAT_RANGE;
        end
      end
      CMD_ROTATE: begin
        if (vi_bad || vj_bad) begin
          status_nxt = STAT_RANGE;
        end else if (vi_r == vj_r) begin
          status_nxt = STAT_SAME;
        end
      end
      default: status_nxt = STAT_OK;
    endcase
    rdres_nxt = (cmd_r == CMD_READ) && (status_nxt == STAT_OK);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        k_nxt  = '0;
        ph_nxt = 1'b0;
        if ((cmd_r == CMD_ROTATE) && (status_nxt == STAT_OK)) begin
          state_nxt = ST_ROT;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_ROT: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          k_nxt = k_r + K_W'(1);
          if ((k_r + K_W'(1)) == n_use) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // All write-backs must land before the store is read again.
        if (!s0_valid_r && !mac_busy) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    ph_r <= ph_nxt;
    if (state_r == ST_EXEC) begin
      status_r <= status_nxt;
      rdres_r  <= rdres_nxt;
    end
  end

  // Store access: the element read in the execute state, and element pair reads on phase 0 of each rotation step.
  always_comb begin
    mem_re      = (state_r == ST_EXEC) || ((state_r == ST_ROT) && !ph_r);
    mem_raddr_a = (state_r == ST_ROT) ? {IW'(vi_r), IW'(k_r)} : {IW'(vi_r), IW'(ei_r)};
    mem_raddr_b = {IW'(vj_r), IW'(k_r)};
  end

  // Write port shared by loads and rotation write-back.
  always_comb begin
    if (q_valid) begin
      mem_we    = 1'b1;
      mem_waddr = {IW'(q_tag.ph ? vj_r : vi_r), IW'(q_tag.k)};
      mem_wdata = q_val;
    end else begin
      mem_we    = (state_r == ST_EXEC) && (cmd_r == CMD_LOAD) && (status_nxt == STAT_OK);
      mem_waddr = {IW'(vi_r), IW'(ei_r)};
      mem_wdata = ld_r;
    end
  end

  grv_store #(
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Operand stage: read data arrives in the cycle after issue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= (state_r == ST_ROT);
    end
  end

  always_ff @(posedge clk) begin
    s0_tag_r.ph <= ph_r;
    s0_tag_r.k  <= k_r;
  end

  grv_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (s0_valid_r),
    .s_tag   (s0_tag_r),
    .x       (rdata_a),
    .y       (rdata_b),
    .c       (c_r),
    .s       (s_r),
    .q_valid (q_valid),
    .q_tag   (q_tag),
    .q_val   (q_val),
    .busy    (mac_busy)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (resp_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      out_read_value_r <= rdres_r ? rdata_a : '0;
      out_status_r     <= status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  // The store is quiet while waiting for a command or presenting a result.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) || (state_r == ST_RESP)) |-> !mem_we)
    else $error("store written outside a command");

  // Rotation write-back only happens while a rotation is in flight.
  a_wb_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ((state_r == ST_ROT) || (state_r == ST_DRAIN)))
    else $error("rotation write-back outside a rotation");

  // A rotation never pairs a vector with itself.
  a_wb_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (vi_r != vj_r))
    else $error("rotation write-back with identical vectors");

  // A failed command answers zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_read_value_r == '0))
    else $error("nonzero data with error status");

endmodule
